// File: sv/periodic_cell_list_binner_assert.svh
// Assertion macros for the periodic cell list binner.
`ifndef PERIODIC_CELL_LIST_BINNER_ASSERT_SVH
`define PERIODIC_CELL_LIST_BINNER_ASSERT_SVH

// Implication checked on every clock, ignored during reset.
`define PCLB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored during reset.
`define PCLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/pclb_pkg.sv
// ----------------------------------------------------------------------------
// pclb_pkg
// Shared types and constants of the periodic cell list binner.
// ----------------------------------------------------------------------------
package pclb_pkg;

   localparam int unsigned LEN_W   = 31;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned ATOM_W  = 13;
   localparam int unsigned BIN_W   = 4;
   localparam int unsigned CSR_W   = 2;

   localparam logic [CSR_W-1:0] CSR_BOX_X = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BOX_Y = 2'd1;
   localparam logic [CSR_W-1:0] CSR_BOX_Z = 2'd2;
   localparam logic [CSR_W-1:0] CSR_RANGE = 2'd3;

   // item handed from front end to back end
   typedef struct packed {
      logic              frame_start;
      logic [ATOM_W-1:0] atom;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_z;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BINS,
      ST_WRAP,
      ST_BIN,
      ST_LOOK,
      ST_OUT
   } back_state_type;

endpackage

// File: sv/periodic_cell_list_binner.sv
// ----------------------------------------------------------------------------
// periodic_cell_list_binner
// Periodic 3-D linked-cell binner: wrap, bin and append one atom per item.
// ----------------------------------------------------------------------------
// Items are binned one at a time; six passes of the shared radix-2 divider
// (nine on frame start) set the rate, and the next item starts only after
// the current one is loaded into the result register.
// Reset: synchronous; bin counts return to one; a clearing pass over every
// occupancy map entry runs before the first item is taken.
// Frame start clears occupancy by bumping an epoch mark; every 255th one
// waits for a clearing pass of the occupancy map instead.
module periodic_cell_list_binner #(
   parameter int unsigned MAX_BINS_PER_DIM = 16,
   parameter int unsigned MAX_ATOMS        = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_frame_start,
   input  logic [12:0] req_atom_index,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_atom_out,
   output logic [30:0] rsp_wrapped_x,
   output logic [30:0] rsp_wrapped_y,
   output logic [30:0] rsp_wrapped_z,
   output logic [3:0]  rsp_bin_x,
   output logic [3:0]  rsp_bin_y,
   output logic [3:0]  rsp_bin_z,
   output logic        rsp_is_head,
   output logic [12:0] rsp_prev_atom,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);
   `include "periodic_cell_list_binner_assert.svh"

   logic [30:0] box_x_ff, box_y_ff, box_z_ff, range_ff;
   pclb_pkg::item_type in_item, q_item;
   logic q_valid, q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= 31'd655360;
         box_y_ff <= 31'd655360;
         box_z_ff <= 31'd655360;
         range_ff <= 31'd163840;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pclb_pkg::CSR_BOX_X: box_x_ff <= csr_data;
            pclb_pkg::CSR_BOX_Y: box_y_ff <= csr_data;
            pclb_pkg::CSR_BOX_Z: box_z_ff <= csr_data;
            pclb_pkg::CSR_RANGE: range_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign in_item = '{frame_start: req_frame_start, atom: req_atom_index,
                      pos_x: req_pos_x, pos_y: req_pos_y, pos_z: req_pos_z};

   pclb_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_stall(req_stall),
      .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
   );

   pclb_back #(.MAX_BINS_PER_DIM(MAX_BINS_PER_DIM), .MAX_ATOMS(MAX_ATOMS)) u_back (
      .clock(clock), .reset(reset),
      .box_x(box_x_ff), .box_y(box_y_ff), .box_z(box_z_ff), .range(range_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_atom(rsp_atom_out), .out_wx(rsp_wrapped_x), .out_wy(rsp_wrapped_y),
      .out_wz(rsp_wrapped_z), .out_bx(rsp_bin_x), .out_by(rsp_bin_y), .out_bz(rsp_bin_z),
      .out_head(rsp_is_head), .out_prev(rsp_prev_atom), .out_status(rsp_status)
   );

   `PCLB_ASSERT_IMPL(a_drop_clean, clock, reset, rsp_valid && rsp_status,
                     !rsp_is_head && rsp_prev_atom == 13'd0, "dropped item has link data")
   `PCLB_ASSERT_IMPL(a_head_prev, clock, reset, rsp_valid && rsp_is_head,
                     rsp_prev_atom == 13'd0, "head item carries a predecessor")
   `PCLB_ASSERT_NEXT(a_pop_valid, clock, reset, q_pop, rsp_valid, "pop without result")
endmodule

// File: sv/pclb_divider.sv
// ----------------------------------------------------------------------------
// pclb_divider
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pclb_divider #(
   parameter int unsigned NUM_W = 40,
   parameter int unsigned DEN_W = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = DEN_W'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;
endmodule

// File: sv/pclb_front.sv
// ----------------------------------------------------------------------------
// pclb_front
// Input stage and two-entry item queue toward the back end.
// ----------------------------------------------------------------------------
module pclb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  pclb_pkg::item_type in_item,
   output logic               q_valid,
   input  logic               q_pop,
   output pclb_pkg::item_type q_item
);
   pclb_pkg::item_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_stall = (cnt_ff == 2'd2);
   assign push     = in_valid && !in_stall;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !(q_pop && q_valid)) cnt_in = cnt_ff + 2'd1;
      else if (!push && q_pop && q_valid) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (q_pop && q_valid) rp_ff <= ~rp_ff;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule

// File: sv/pclb_back.sv
// ----------------------------------------------------------------------------
// pclb_back
// Sequencer: bin counts, wrap, bin index, chain append, result register.
// ----------------------------------------------------------------------------
module pclb_back #(
   parameter int unsigned MAX_BINS_PER_DIM = 16,
   parameter int unsigned MAX_ATOMS        = 8192
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pclb_pkg::LEN_W-1:0]    box_x,
   input  logic [pclb_pkg::LEN_W-1:0]    box_y,
   input  logic [pclb_pkg::LEN_W-1:0]    box_z,
   input  logic [pclb_pkg::LEN_W-1:0]    range,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  pclb_pkg::item_type            q_item,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic [pclb_pkg::ATOM_W-1:0]   out_atom,
   output logic [pclb_pkg::LEN_W-1:0]    out_wx,
   output logic [pclb_pkg::LEN_W-1:0]    out_wy,
   output logic [pclb_pkg::LEN_W-1:0]    out_wz,
   output logic [pclb_pkg::BIN_W-1:0]    out_bx,
   output logic [pclb_pkg::BIN_W-1:0]    out_by,
   output logic [pclb_pkg::BIN_W-1:0]    out_bz,
   output logic                          out_head,
   output logic [pclb_pkg::ATOM_W-1:0]   out_prev,
   output logic                          out_status
);
   localparam int unsigned LW    = pclb_pkg::LEN_W;
   localparam int unsigned NB_W  = $clog2(MAX_BINS_PER_DIM + 1);
   localparam int unsigned BI_W  = (MAX_BINS_PER_DIM > 1) ? $clog2(MAX_BINS_PER_DIM) : 1;
   localparam int unsigned CELLS = MAX_BINS_PER_DIM * MAX_BINS_PER_DIM * MAX_BINS_PER_DIM;
   localparam int unsigned CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int unsigned NUM_W = pclb_pkg::POS_W + 1 + NB_W;
   localparam int unsigned EPW   = 8;

   pclb_pkg::back_state_type st_ff, st_in;
   logic [1:0] ax_ff, ax_in;

   logic [NB_W-1:0] nb_ff [3];
   logic [LW-1:0]   w_ff  [3];
   logic [NUM_W-1:0] q_ff [3];
   logic             neg_ff;

   // divider
   logic             dv_start;
   logic [NUM_W-1:0] dv_num;
   logic [LW-1:0]    dv_den;
   logic             dv_done;
   logic [NUM_W-1:0] dv_quot;
   logic [LW-1:0]    dv_rem;

   pclb_divider #(.NUM_W(NUM_W), .DEN_W(LW)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .numer(dv_num), .denom(dv_den),
      .done(dv_done), .quot(dv_quot), .rem(dv_rem)
   );

   // occupancy by frame epoch, tail table
   // epoch 0 marks a cleared entry; live epochs run 1 to all ones
   logic [EPW-1:0]  epoch_ff;
   logic [EPW-1:0]  occ_mem [CELLS];
   logic [pclb_pkg::ATOM_W-1:0] tail_mem [CELLS];
   logic [EPW-1:0]  occ_rd_ff;
   logic [pclb_pkg::ATOM_W-1:0] tail_rd_ff;
   logic [1:0]      look_ff;
   logic [CW-1:0]   slot;
   logic            bad;
   logic            head;
   logic            clr_busy_ff;
   logic [CW-1:0]   clr_addr_ff;
   logic            go;
   logic            wrap_clr;

   logic [LW-1:0] box_sel, box_eff;
   logic [pclb_pkg::POS_W-1:0] pos_sel;
   logic [pclb_pkg::POS_W:0]   pos_abs;

   function automatic logic [LW-1:0] wrap_val(input logic [LW-1:0] r, input logic n,
                                              input logic [LW-1:0] b);
      wrap_val = (n && r != '0) ? LW'(b - r) : r;
   endfunction

   function automatic logic [pclb_pkg::POS_W:0] abs_of(input logic [pclb_pkg::POS_W-1:0] p);
      abs_of = p[pclb_pkg::POS_W-1]
             ? (pclb_pkg::POS_W+1)'(-$signed({p[pclb_pkg::POS_W-1], p}))
             : {1'b0, p};
   endfunction

   // epoch wrap: hold the frame start item until the clearing pass is done
   assign wrap_clr = q_valid && !clr_busy_ff && q_item.frame_start
                     && (epoch_ff == {EPW{1'b1}});
   assign go       = q_valid && !clr_busy_ff && !wrap_clr;

   always_comb begin
      case (ax_ff)
         2'd0:    begin box_sel = box_x; pos_sel = q_item.pos_x; end
         2'd1:    begin box_sel = box_y; pos_sel = q_item.pos_y; end
         default: begin box_sel = box_z; pos_sel = q_item.pos_z; end
      endcase
      box_eff = (box_sel == '0) ? LW'(1) : box_sel;
      pos_abs = pos_sel[pclb_pkg::POS_W-1]
              ? (pclb_pkg::POS_W+1)'(-$signed({pos_sel[pclb_pkg::POS_W-1], pos_sel}))
              : {1'b0, pos_sel};
   end

   always_comb begin
      bad = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (q_ff[i] >= NUM_W'(nb_ff[i])) bad = 1'b1;
         if (q_ff[i] >= NUM_W'(MAX_BINS_PER_DIM)) bad = 1'b1;
      end
      if (32'(q_item.atom) >= 32'(MAX_ATOMS)) bad = 1'b1;
      slot = CW'((q_ff[0][BI_W-1:0] * MAX_BINS_PER_DIM + q_ff[1][BI_W-1:0])
                 * MAX_BINS_PER_DIM + q_ff[2][BI_W-1:0]);
      head = (occ_rd_ff != epoch_ff);
   end

   // next state
   always_comb begin
      st_in = st_ff;
      ax_in = ax_ff;
      case (st_ff)
         pclb_pkg::ST_IDLE: if (go) begin
            ax_in = 2'd0;
            st_in = q_item.frame_start ? pclb_pkg::ST_BINS : pclb_pkg::ST_WRAP;
         end
         pclb_pkg::ST_BINS: if (dv_done) begin
            ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
            if (ax_ff == 2'd2) st_in = pclb_pkg::ST_WRAP;
         end
         pclb_pkg::ST_WRAP: if (dv_done) st_in = pclb_pkg::ST_BIN;
         pclb_pkg::ST_BIN: if (dv_done) begin
            ax_in = (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
            st_in = (ax_ff == 2'd2) ? pclb_pkg::ST_LOOK : pclb_pkg::ST_WRAP;
         end
         pclb_pkg::ST_LOOK: if (look_ff == 2'd2) st_in = pclb_pkg::ST_OUT;
         pclb_pkg::ST_OUT: if (!out_valid || !out_stall) st_in = pclb_pkg::ST_IDLE;
         default: st_in = pclb_pkg::ST_IDLE;
      endcase
   end

   // divider control
   always_comb begin
      dv_start = 1'b0;
      dv_num   = '0;
      dv_den   = box_eff;
      case (st_ff)
         pclb_pkg::ST_IDLE: if (go) begin
            dv_start = 1'b1;
            if (q_item.frame_start) begin
               dv_num = NUM_W'(box_eff);
               dv_den = (range == '0) ? LW'(1) : range;
            end else begin
               dv_num = NUM_W'(pos_abs);
            end
         end
         pclb_pkg::ST_BINS: if (dv_done) begin
            dv_start = 1'b1;
            if (ax_ff != 2'd2) begin
               case (ax_ff)
                  2'd0:    dv_num = NUM_W'((box_y == '0) ? LW'(1) : box_y);
                  default: dv_num = NUM_W'((box_z == '0) ? LW'(1) : box_z);
               endcase
               dv_den = (range == '0) ? LW'(1) : range;
            end else begin
               dv_num = NUM_W'(abs_of(q_item.pos_x));
               dv_den = (box_x == '0) ? LW'(1) : box_x;
            end
         end
         pclb_pkg::ST_WRAP: if (dv_done) begin
            dv_start = 1'b1;
            dv_num   = NUM_W'(wrap_val(dv_rem, neg_ff, box_eff)) * NUM_W'(nb_ff[ax_ff]);
         end
         pclb_pkg::ST_BIN: if (dv_done && ax_ff != 2'd2) begin
            dv_start = 1'b1;
            case (ax_ff)
               2'd0:    begin dv_num = NUM_W'(abs_of(q_item.pos_y));
                              dv_den = (box_y == '0) ? LW'(1) : box_y; end
               default: begin dv_num = NUM_W'(abs_of(q_item.pos_z));
                              dv_den = (box_z == '0) ? LW'(1) : box_z; end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= pclb_pkg::ST_IDLE;
         ax_ff       <= '0;
         epoch_ff    <= EPW'(1);
         look_ff     <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         for (int i = 0; i < 3; i++) nb_ff[i] <= NB_W'(1);
      end else begin
         st_ff <= st_in;
         ax_ff <= ax_in;
         if (st_ff == pclb_pkg::ST_IDLE && go && q_item.frame_start)
            epoch_ff <= epoch_ff + EPW'(1);
         if (st_ff == pclb_pkg::ST_IDLE && wrap_clr) begin
            epoch_ff    <= '0;
            clr_busy_ff <= 1'b1;
            clr_addr_ff <= '0;
         end else if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + CW'(1);
            if (clr_addr_ff == CW'(CELLS - 1)) clr_busy_ff <= 1'b0;
         end
         if (st_ff == pclb_pkg::ST_BINS && dv_done) begin
            if (dv_quot >= NUM_W'(MAX_BINS_PER_DIM) || range == '0)
               nb_ff[ax_ff] <= NB_W'(MAX_BINS_PER_DIM);
            else if (dv_quot == '0)
               nb_ff[ax_ff] <= NB_W'(1);
            else
               nb_ff[ax_ff] <= NB_W'(dv_quot);
         end
         if (st_ff == pclb_pkg::ST_LOOK) look_ff <= look_ff + 2'd1;
         else look_ff <= '0;
      end
      if ((st_ff == pclb_pkg::ST_IDLE || st_ff == pclb_pkg::ST_BIN) && dv_start)
         neg_ff <= (st_ff == pclb_pkg::ST_IDLE) ? pos_sel[pclb_pkg::POS_W-1]
                 : ((ax_ff == 2'd0) ? q_item.pos_y[pclb_pkg::POS_W-1]
                                    : q_item.pos_z[pclb_pkg::POS_W-1]);
      else if (st_ff == pclb_pkg::ST_BINS && dv_done && ax_ff == 2'd2)
         neg_ff <= q_item.pos_x[pclb_pkg::POS_W-1];
      if (st_ff == pclb_pkg::ST_WRAP && dv_done) w_ff[ax_ff] <= wrap_val(dv_rem, neg_ff, box_eff);
      if (st_ff == pclb_pkg::ST_BIN && dv_done) q_ff[ax_ff] <= dv_quot;
      if (clr_busy_ff) occ_mem[clr_addr_ff] <= '0;
      if (st_ff == pclb_pkg::ST_LOOK && look_ff == 2'd0) begin
         occ_rd_ff  <= occ_mem[slot];
         tail_rd_ff <= tail_mem[slot];
      end
      if (st_ff == pclb_pkg::ST_LOOK && look_ff == 2'd1 && !bad) begin
         occ_mem[slot]  <= epoch_ff;
         tail_mem[slot] <= q_item.atom;
      end
      if (q_pop) begin
         out_atom   <= q_item.atom;
         out_wx     <= w_ff[0];
         out_wy     <= w_ff[1];
         out_wz     <= w_ff[2];
         out_bx     <= pclb_pkg::BIN_W'(q_ff[0]);
         out_by     <= pclb_pkg::BIN_W'(q_ff[1]);
         out_bz     <= pclb_pkg::BIN_W'(q_ff[2]);
         out_status <= bad;
         out_head   <= !bad && head;
         out_prev   <= (bad || head) ? '0 : tail_rd_ff;
      end
   end

   // output register
   logic ov_ff;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (st_ff == pclb_pkg::ST_OUT && (!ov_ff || !out_stall)) ov_ff <= 1'b1;
      else if (!out_stall) ov_ff <= 1'b0;
   end
   assign out_valid = ov_ff;
   assign q_pop = (st_ff == pclb_pkg::ST_OUT) && (!ov_ff || !out_stall);
endmodule

// File: bench/tb_periodic_cell_list_binner.sv
// ----------------------------------------------------------------------------
// tb_periodic_cell_list_binner
// Self-checking bench for the periodic cell list binner.
// A short directed table covers reset bin counts, extreme positions and
// atoms, zero box and zero range settings and the bin count clamps. Random
// frames then follow under several box and range settings. Every result is
// compared to a typed row or a local model of wrap, bin and chain append.
// ----------------------------------------------------------------------------
module tb_periodic_cell_list_binner;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;
   localparam int   BINS_MAX       = 16;
   localparam int   ATOMS_MAX      = 8192;
   localparam int   SETTLE_CYCLES  = 400;

   typedef struct packed {
      logic [12:0] atom;
      logic [30:0] wx;
      logic [30:0] wy;
      logic [30:0] wz;
      logic [3:0]  bx;
      logic [3:0]  by;
      logic [3:0]  bz;
      logic        head;
      logic [12:0] prev;
      logic        status;
   } binned_type;

   typedef struct {
      logic        fs;
      logic [12:0] atom;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      bit          typed;
      binned_type  res;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_frame_start = 1'b0;
   logic [12:0] req_atom_index = '0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [12:0] rsp_atom_out;
   logic [30:0] rsp_wrapped_x;
   logic [30:0] rsp_wrapped_y;
   logic [30:0] rsp_wrapped_z;
   logic [3:0]  rsp_bin_x;
   logic [3:0]  rsp_bin_y;
   logic [3:0]  rsp_bin_z;
   logic        rsp_is_head;
   logic [12:0] rsp_prev_atom;
   logic        rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [30:0] csr_data = '0;

   periodic_cell_list_binner dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state
   logic [30:0] box_x, box_y, box_z, nrange;
   int          bins_x, bins_y, bins_z;
   bit          occupied [4096];
   logic [12:0] tail [4096];

   binned_type  pending_bins [$];
   int          errors = 0;
   bit          quiet = 1'b0;
   bit          hold_go = 1'b0;
   int          rsp_wait = 0;

   function automatic longint eff_len(logic [30:0] b);
      return (b == 0) ? 1 : longint'(b);
   endfunction

   function automatic int bins_for(logic [30:0] b);
      longint q;
      if (nrange == 0) return BINS_MAX;
      q = eff_len(b) / longint'(nrange);
      if (q < 1) q = 1;
      if (q > BINS_MAX) q = BINS_MAX;
      return int'(q);
   endfunction

   function automatic logic [30:0] wrap_axis(logic [31:0] p, logic [30:0] b);
      longint r;
      r = longint'(signed'(p)) % eff_len(b);
      if (r < 0) r += eff_len(b);
      return r[30:0];
   endfunction

   function automatic binned_type bin_atom(logic fs, logic [12:0] atom,
                                           logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z);
      binned_type r;
      longint     bx, by, bz;
      int         slot;
      if (fs) begin
         bins_x = bins_for(box_x);
         bins_y = bins_for(box_y);
         bins_z = bins_for(box_z);
         foreach (occupied[i]) occupied[i] = 1'b0;
      end
      r = '0;
      r.atom = atom;
      r.wx = wrap_axis(x, box_x);
      r.wy = wrap_axis(y, box_y);
      r.wz = wrap_axis(z, box_z);
      bx = (longint'(r.wx) * bins_x) / eff_len(box_x);
      by = (longint'(r.wy) * bins_y) / eff_len(box_y);
      bz = (longint'(r.wz) * bins_z) / eff_len(box_z);
      r.bx = bx[3:0];
      r.by = by[3:0];
      r.bz = bz[3:0];
      if (bx >= bins_x || by >= bins_y || bz >= bins_z || bx >= BINS_MAX ||
          by >= BINS_MAX || bz >= BINS_MAX || int'(atom) >= ATOMS_MAX) begin
         r.status = STATUS_DROPPED;
      end else begin
         r.status = STATUS_OK;
         slot = int'({bx[3:0], by[3:0], bz[3:0]});
         if (!occupied[slot]) begin
            r.head = 1'b1;
            occupied[slot] = 1'b1;
         end else begin
            r.prev = tail[slot];
         end
         tail[slot] = atom;
      end
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
   endtask

   // result side
   always @(posedge clock) begin
      binned_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bins.size() == 0) begin
            report("unexpected item atom", 32'(rsp_atom_out), 32'd0);
         end else begin
            w = pending_bins.pop_front();
            if (rsp_atom_out  !== w.atom)
               report("atom_out", 32'(rsp_atom_out), 32'(w.atom));
            if (rsp_wrapped_x !== w.wx)
               report("wrapped_x", 32'(rsp_wrapped_x), 32'(w.wx));
            if (rsp_wrapped_y !== w.wy)
               report("wrapped_y", 32'(rsp_wrapped_y), 32'(w.wy));
            if (rsp_wrapped_z !== w.wz)
               report("wrapped_z", 32'(rsp_wrapped_z), 32'(w.wz));
            if (rsp_bin_x     !== w.bx)     report("bin_x", 32'(rsp_bin_x), 32'(w.bx));
            if (rsp_bin_y     !== w.by)     report("bin_y", 32'(rsp_bin_y), 32'(w.by));
            if (rsp_bin_z     !== w.bz)     report("bin_z", 32'(rsp_bin_z), 32'(w.bz));
            if (rsp_is_head   !== w.head)
               report("is_head", 32'(rsp_is_head), 32'(w.head));
            if (rsp_prev_atom !== w.prev)
               report("prev_atom", 32'(rsp_prev_atom), 32'(w.prev));
            if (rsp_status    !== w.status)
               report("status", 32'(rsp_status), 32'(w.status));
         end
         rsp_wait = quiet ? 0 : $urandom_range(0, 8);
      end
   end

   always @(negedge clock) begin
      rsp_stall <= hold_go || (rsp_wait > 0);
      if (rsp_wait > 0) rsp_wait = rsp_wait - 1;
   end

   // long receiver hold-off
   always begin
      wait (hold_go);
      repeat (2500) @(posedge clock);
      hold_go = 1'b0;
   end

   task automatic write_reg(logic [1:0] idx, logic [30:0] val);
      csr_index = idx;
      csr_data  = val;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         pclb_pkg::CSR_BOX_X: box_x = val;
         pclb_pkg::CSR_BOX_Y: box_y = val;
         pclb_pkg::CSR_BOX_Z: box_z = val;
         pclb_pkg::CSR_RANGE: nrange = val;
         default: ;
      endcase
   endtask

   task automatic set_box(logic [30:0] bx, logic [30:0] by, logic [30:0] bz,
                          logic [30:0] rng);
      write_reg(pclb_pkg::CSR_BOX_X, bx);
      write_reg(pclb_pkg::CSR_BOX_Y, by);
      write_reg(pclb_pkg::CSR_BOX_Z, bz);
      write_reg(pclb_pkg::CSR_RANGE, rng);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      wait (pending_bins.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_atom(row_type r);
      int         gap;
      binned_type p;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_frame_start = r.fs;
      req_atom_index  = r.atom;
      req_pos_x       = r.x;
      req_pos_y       = r.y;
      req_pos_z       = r.z;
      req_valid       = 1'b1;
      do @(posedge clock); while (req_stall);
      p = bin_atom(r.fs, r.atom, r.x, r.y, r.z);
      pending_bins.push_back(r.typed ? r.res : p);
      @(negedge clock);
   endtask

   function automatic logic [30:0] rand_len();
      case ($urandom_range(0, 5))
         0: return 31'd65536;
         1: return 31'h7fffffff;
         2: return 31'($urandom_range(65536, 31'h7fffffff));
         default: return 31'($urandom_range(65536, 40 * 65536));
      endcase
   endfunction

   function automatic logic [31:0] rand_pos(logic [30:0] b);
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, b);
         2: return -$urandom_range(0, b);
         default: return $urandom_range(0, 4 * b) - 2 * b;
      endcase
   endfunction

   row_type table_rows [] = '{
      '{1'b0, 13'd0,    32'h0,        32'h0,        32'h0,        1'b1,
        '{13'd0, 31'd0, 31'd0, 31'd0, 4'd0, 4'd0, 4'd0, 1'b1, 13'd0, STATUS_OK}},
      '{1'b0, 13'd8191, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1,
        '{13'd8191, 31'd524287, 31'd524287, 31'd524287, 4'd0, 4'd0, 4'd0,
          1'b0, 13'd0, STATUS_OK}},
      '{1'b1, 13'd5,    32'hffffffff, 32'h80000000, 32'h0,        1'b1,
        '{13'd5, 31'd655359, 31'd131072, 31'd0, 4'd3, 4'd0, 4'd0,
          1'b1, 13'd0, STATUS_OK}},
      '{1'b0, 13'd6,    32'hffffffff, 32'h80000000, 32'h0,        1'b0, '0},
      '{1'b0, 13'd5,    32'h000a0000, 32'h00140000, 32'hfff60000, 1'b0, '0},
      '{1'b0, 13'h0aaa, 32'h00028000, 32'h00050000, 32'h00078000, 1'b0, '0},
      '{1'b0, 13'h1555, 32'h00027fff, 32'h0004ffff, 32'h00077fff, 1'b0, '0},
      '{1'b1, 13'd7,    32'h00028000, 32'h00028000, 32'h00028000, 1'b0, '0}
   };

   initial begin
      row_type r;
      int      n;
      box_x = 31'd655360; box_y = 31'd655360; box_z = 31'd655360;
      nrange = 31'd163840;
      bins_x = 1; bins_y = 1; bins_z = 1;
      foreach (occupied[i]) occupied[i] = 1'b0;
      foreach (tail[i]) tail[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[i]) send_atom(table_rows[i]);
      drain();

      // smallest box, smallest range: clamps to the top bin count
      set_box(31'd65536, 31'd65536, 31'd65536, 31'd1);
      foreach (table_rows[i]) begin
         r = table_rows[i];
         r.typed = 1'b0;
         send_atom(r);
      end
      drain();
      // largest box and range, then zero range, then zero box
      set_box(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      r = table_rows[2]; r.typed = 1'b0; send_atom(r);
      r = table_rows[1]; r.typed = 1'b0; send_atom(r);
      drain();
      write_reg(pclb_pkg::CSR_RANGE, 31'd0);
      r = table_rows[2]; r.typed = 1'b0; send_atom(r);
      r = table_rows[4]; send_atom(r);
      drain();
      set_box(31'd0, 31'd0, 31'd0, 31'd163840);
      r = table_rows[2]; r.typed = 1'b0; send_atom(r);
      r = table_rows[5]; send_atom(r);
      drain();
      write_reg(pclb_pkg::CSR_RANGE, 31'd0);
      r = table_rows[7]; r.typed = 1'b0; send_atom(r);
      r = table_rows[6]; send_atom(r);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         set_box(rand_len(), rand_len(), rand_len(),
                 ($urandom_range(0, 4) == 0) ? 31'($urandom_range(0, 31'h7fffffff))
                                             : 31'($urandom_range(1, 10 * 65536)));
         quiet = (phase == 2);
         if (phase == 1) hold_go = 1'b1;
         n = 0;
         while (n < 310) begin
            r.fs    = (n == 0) || ($urandom_range(0, 39) == 0);
            r.atom  = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 31))
                                                  : 13'($urandom());
            r.x     = rand_pos(box_x);
            r.y     = rand_pos(box_y);
            r.z     = rand_pos(box_z);
            r.typed = 1'b0;
            r.res   = '0;
            send_atom(r);
            n++;
         end
         drain();
      end
      quiet = 1'b0;

      req_valid = 1'b0;
      fork
         wait (pending_bins.size() == 0);
         repeat (200000) @(posedge clock);
      join_any
      disable fork;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_bins.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
